[design/cssp_pkg.sv]
package cssp_pkg;

   // field widths
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned ID_W      = 48;
   localparam int unsigned LIMIT_W   = 4;
   localparam int unsigned CNT_W     = 3;
   localparam int unsigned TIMEOUT_W = 4;

   // bytes that follow the id start byte in an id capture
   localparam int unsigned ID_LENGTH = 6;

   // result queue
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = 2;
   localparam int unsigned FILL_W     = 3;

   // status and message codes
   localparam logic [BYTE_W-1:0] CODE_DISCONNECT = 8'h60;
   localparam logic [BYTE_W-1:0] CODE_STANDBY    = 8'h61;
   localparam logic [BYTE_W-1:0] CODE_PROFILE_A  = 8'h62;
   localparam logic [BYTE_W-1:0] CODE_PROFILE_B  = 8'h63;
   localparam logic [BYTE_W-1:0] CODE_METAL_A    = 8'h64;
   localparam logic [BYTE_W-1:0] CODE_METAL_B    = 8'h65;
   localparam logic [BYTE_W-1:0] CODE_METAL_C    = 8'h66;
   localparam logic [BYTE_W-1:0] CODE_PROFILE_C  = 8'h68;
   localparam logic [BYTE_W-1:0] CODE_ID_START   = 8'h71;

   localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 4'd5;

   // eight-byte message buffer, byte 0 in the low bits
   typedef logic [7:0][BYTE_W-1:0] msg_buf_type;

   // one queued result message
   typedef struct packed {
      logic [ID_W-1:0]   id_bytes;
      logic [BYTE_W-1:0] tag_byte;
      logic [BYTE_W-1:0] lead_byte;
      logic              is_disconnect;
      logic              last;
   } rsp_item_type;

   function automatic logic is_alert(input logic [BYTE_W-1:0] code);
      return (code == CODE_STANDBY) || (code == CODE_METAL_A) ||
             (code == CODE_METAL_B) || (code == CODE_METAL_C);
   endfunction

   function automatic logic is_profile(input logic [BYTE_W-1:0] code);
      return (code == CODE_PROFILE_A) || (code == CODE_PROFILE_B) ||
             (code == CODE_PROFILE_C);
   endfunction

endpackage

[design/charger_status_stream_parser_top.sv]
// channel   | ports                              | payload
// ----------+------------------------------------+---------------------------------------
// request   | req_tvalid req_tready req_tdata/tuser | tdata: rx_byte; tuser: has_byte
// response  | rsp_tvalid rsp_tready rsp_tdata/tuser/tlast | tdata: lead, tag, id; tuser: disc
// config    | csr_we csr_wdata                   | idle_poll_limit
//
// One request is taken per cycle while req_tready is high; its messages (zero, one
// or two) are produced in the same cycle into a four-entry response queue and leave
// one per cycle while rsp_tready is high. req_tready is high while the queue has
// room for two messages.
// Reset is synchronous and active high; it restores the parser state and sets
// the idle poll limit to 5. A stalled response side only fills the queue.
module charger_status_stream_parser_top (
   input  logic                       clock,
   input  logic                       reset,
   // request
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [cssp_pkg::BYTE_W-1:0] req_tdata,  // [7:0] rx_byte
   input  logic                       req_tuser,  // [0] has_byte
   // response
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,  // [7:0] lead_byte, [15:8] tag_byte,
                                                  // [63:16] id_bytes
   output logic                       rsp_tuser,  // [0] is_disconnect
   output logic                       rsp_tlast,  // last message of the poll
   // configuration
   input  logic                       csr_we,
   input  logic [cssp_pkg::LIMIT_W-1:0] csr_wdata  // idle_poll_limit
);
   import cssp_pkg::*;

   // parser state
   msg_buf_type          msg_ff,      msg_in;
   logic [BYTE_W-1:0]    prev_ff,     prev_in;
   logic [BYTE_W-1:0]    profile_ff,  profile_in;
   logic                 capture_ff,  capture_in;
   logic [CNT_W-1:0]     cnt_ff,      cnt_in;
   logic                 after_status_ff, after_status_in;
   logic                 underrun_ff, underrun_in;
   logic [TIMEOUT_W-1:0] timeout_ff,  timeout_in;
   logic [LIMIT_W-1:0]   limit_ff;

   // response queue
   rsp_item_type         fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff,   wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff,   rd_ptr_in;
   logic [FILL_W-1:0]    fill_ff,     fill_in;

   logic                 accept;
   logic                 pop;
   logic                 data_emit;
   logic                 disc_emit;
   rsp_item_type         data_item;
   rsp_item_type         disc_item;
   logic [PTR_W-1:0]     disc_addr;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (fill_ff <= FILL_W'(FIFO_DEPTH - 2));
   assign rsp_tvalid = (fill_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   // response port view of the queue head
   assign rsp_tdata = {fifo_ff[rd_ptr_ff].id_bytes, fifo_ff[rd_ptr_ff].tag_byte,
                       fifo_ff[rd_ptr_ff].lead_byte};
   assign rsp_tuser = fifo_ff[rd_ptr_ff].is_disconnect;
   assign rsp_tlast = fifo_ff[rd_ptr_ff].last;

   // one poll through the parser
   always_comb begin
      msg_buf_type          m;
      logic [BYTE_W-1:0]    b;
      logic [BYTE_W-1:0]    lead;
      logic [CNT_W-1:0]     slot;
      logic [TIMEOUT_W-1:0] tc;

      m               = msg_ff;
      b               = req_tdata;
      lead            = '0;
      slot            = '0;
      tc              = timeout_ff;
      prev_in         = prev_ff;
      profile_in      = profile_ff;
      capture_in      = capture_ff;
      cnt_in          = cnt_ff;
      after_status_in = after_status_ff;
      underrun_in     = underrun_ff;
      data_emit       = 1'b0;
      disc_emit       = 1'b0;
      data_item       = '0;
      disc_item       = '0;

      if (req_tuser) begin
         if (capture_ff) begin
            // id capture in progress
            cnt_in    = cnt_ff + CNT_W'(1);
            slot      = cnt_in + CNT_W'(1);
            m[slot]   = b;
            if (cnt_in == CNT_W'(ID_LENGTH)) begin
               capture_in = 1'b0;
               cnt_in     = '0;
               if (after_status_ff && (m[0] != '0) && (m[0] == profile_ff) &&
                   (m[1] == CODE_ID_START) && (m[0] != CODE_STANDBY)) begin
                  data_emit       = 1'b1;
                  after_status_in = 1'b0;
               end else if (is_alert(m[0])) begin
                  lead            = m[0];
                  m               = '0;
                  m[0]            = lead;
                  data_emit       = 1'b1;
                  after_status_in = 1'b0;
               end
            end
         end else if (b == CODE_ID_START) begin
            capture_in = 1'b1;
            m[0]       = profile_ff;
            m[1]       = CODE_ID_START;
         end else if (b == prev_ff) begin
            // repeated status byte
            if (is_alert(b)) begin
               cnt_in          = '0;
               m[0]            = b;
               after_status_in = 1'b1;
               data_emit       = 1'b1;
            end else if (is_profile(b)) begin
               cnt_in     = '0;
               profile_in = b;
               m[0]       = b;
            end
         end else begin
            prev_in = b;
         end
      end else begin
         underrun_in = 1'b1;
      end

      // data message snapshot, buffer cleared after it
      if (data_emit) begin
         data_item.lead_byte     = m[0];
         data_item.tag_byte      = m[1];
         data_item.id_bytes      = m[7:2];
         data_item.is_disconnect = 1'b0;
         m                       = '0;
      end

      // idle timeout
      if (underrun_in) begin
         tc = tc + TIMEOUT_W'(1);
         if (tc == limit_ff) begin
            disc_emit               = 1'b1;
            disc_item.lead_byte     = CODE_DISCONNECT;
            disc_item.tag_byte      = m[1];
            disc_item.id_bytes      = m[7:2];
            disc_item.is_disconnect = 1'b1;
            disc_item.last          = 1'b1;
            m                       = '0;
            prev_in                 = '0;
            profile_in              = '0;
            cnt_in                  = '0;
            after_status_in         = 1'b1;
            underrun_in             = 1'b0;
            tc                      = '0;
         end
      end

      data_item.last = !disc_emit;
      msg_in         = m;
      timeout_in     = tc;
   end

   // queue pointers and fill level
   assign disc_addr = wr_ptr_ff + PTR_W'(data_emit);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(data_emit) + PTR_W'(disc_emit);
         fill_in   = fill_ff + FILL_W'(data_emit) + FILL_W'(disc_emit);
      end
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      if (pop) begin
         fill_in = fill_in - FILL_W'(1);
      end
   end

   // parser and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         msg_ff          <= '0;
         prev_ff         <= '0;
         profile_ff      <= '0;
         capture_ff      <= 1'b0;
         cnt_ff          <= '0;
         after_status_ff <= 1'b1;
         underrun_ff     <= 1'b0;
         timeout_ff      <= '0;
         limit_ff        <= IDLE_LIMIT_RESET;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fill_ff         <= '0;
      end else begin
         if (accept) begin
            msg_ff          <= msg_in;
            prev_ff         <= prev_in;
            profile_ff      <= profile_in;
            capture_ff      <= capture_in;
            cnt_ff          <= cnt_in;
            after_status_ff <= after_status_in;
            underrun_ff     <= underrun_in;
            timeout_ff      <= timeout_in;
         end
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept && data_emit) begin
         fifo_ff[wr_ptr_ff] <= data_item;
      end
      if (accept && disc_emit) begin
         fifo_ff[disc_addr] <= disc_item;
      end
   end

endmodule

[design/cssp_checker.sv]
module cssp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [63:0]                  rsp_tdata,
   input logic                         rsp_tuser,
   input logic                         rsp_tlast
);
   import cssp_pkg::*;

   // response is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // disconnect carries its code and closes the poll
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[7:0] == CODE_DISCONNECT))
      else $error("malformed disconnect message");

   // a data message leads with a nonzero code other than disconnect
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
      (rsp_tdata[7:0] != CODE_DISCONNECT) && (rsp_tdata[7:0] != '0))
      else $error("data message with bad lead byte");

   // a response stays valid after a poll is taken while the response side stalls
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tready && rsp_tvalid |=> rsp_tvalid)
      else $error("response dropped while stalled");

endmodule

bind charger_status_stream_parser_top cssp_checker u_cssp_checker (.*);
